/* sv/ftpe_pkg.sv */
// Shared types, constants and helpers for the fat-tree parent and edge indexer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ftpe_pkg;

   localparam int TREE_HEIGHT = 3;
   localparam int MAX_LINKS   = 64;
   localparam int LEVELS      = 4;

   localparam int LINK_W      = 7;
   localparam int DIGIT_W     = 6;
   localparam int LAYER_W     = 3;
   localparam int NODE_W      = 27;
   localparam int EDGE_W      = 32;
   localparam int LVL_IDX_W   = 2;
   localparam int CSR_INDEX_W = 3;

   // Horner partial sums grow by one radix per step.
   localparam int H1_W   = DIGIT_W + LINK_W;
   localparam int H2_W   = H1_W + LINK_W;
   localparam int H3_W   = H2_W + LINK_W;
   localparam int PAIR_W = 2 * LINK_W;
   localparam int SIZE_W = 4 * LINK_W;

   // Stages of the item pipeline that carry context, ahead of the result register.
   localparam int CTX_STAGES = 5;

   localparam int SETTLE_W = 3;

   typedef logic [LINK_W-1:0]      link_type;
   typedef logic [DIGIT_W-1:0]     digit_type;
   typedef logic [LAYER_W-1:0]     layer_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [SETTLE_W-1:0]    settle_type;

   localparam link_type   MAX_LINKS_VAL = link_type'(MAX_LINKS);
   localparam link_type   UNIT_RADIX    = link_type'(1);
   localparam layer_type  TOP_LAYER     = layer_type'(TREE_HEIGHT);
   localparam layer_type  LAYER_ONE     = layer_type'(1);
   // Depth of the registered link-product chain in the link table.
   localparam settle_type SETTLE_CYCLES = settle_type'(4);

   localparam csr_index_type CSR_UP_LINKS_0   = csr_index_type'(0);
   localparam csr_index_type CSR_UP_LINKS_1   = csr_index_type'(1);
   localparam csr_index_type CSR_UP_LINKS_2   = csr_index_type'(2);
   localparam csr_index_type CSR_UP_LINKS_3   = csr_index_type'(3);
   localparam csr_index_type CSR_DOWN_LINKS_0 = csr_index_type'(4);
   localparam csr_index_type CSR_DOWN_LINKS_1 = csr_index_type'(5);
   localparam csr_index_type CSR_DOWN_LINKS_2 = csr_index_type'(6);
   localparam csr_index_type CSR_DOWN_LINKS_3 = csr_index_type'(7);

   typedef struct packed {
      layer_type                child_layer;
      digit_type [LEVELS-1:0]   child_digit;
      layer_type                root_layer;
      digit_type [LEVELS-1:0]   root_digit;
   } query_type;

   typedef struct packed {
      link_type [LEVELS-1:0]           up_links;
      link_type [LEVELS-1:0]           down_links;
      logic [LEVELS:0][NODE_W-1:0]     node_offset;
      logic [LEVELS-1:0][EDGE_W-1:0]   edge_offset;
   } links_type;

   typedef struct packed {
      logic                     reached_root;
      layer_type                parent_layer;
      logic [NODE_W-1:0]        parent_node_id;
      logic [EDGE_W-1:0]        edge_id;
      digit_type [LEVELS-1:0]   parent_digit;
   } result_type;

   // Radix of one digit position for a node on the given layer. Levels below the
   // layer count uplinks, the others downlinks; levels above the tree count one.
   function automatic link_type level_radix(input link_type [LEVELS-1:0] up,
                                            input link_type [LEVELS-1:0] down,
                                            input int level,
                                            input layer_type layer);
      link_type radix;
      if (level >= TREE_HEIGHT) begin
         radix = UNIT_RADIX;
      end else if (level < int'(layer)) begin
         radix = up[level];
      end else begin
         radix = down[level];
      end
      return radix;
   endfunction

endpackage

/* sv/ftpe_link_table.sv */
// Link-count registers and the layer sizes and offsets derived from them.
// Depends on ftpe_pkg.
`timescale 1ns / 1ps

module ftpe_link_table (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  ftpe_pkg::csr_index_type  csr_index,
   input  ftpe_pkg::link_type       csr_wdata,
   output ftpe_pkg::links_type      links
);
   import ftpe_pkg::*;

   link_type [LEVELS-1:0]          up_ff, up_in;
   link_type [LEVELS-1:0]          down_ff, down_in;
   link_type                       wr_value;
   logic [LEVELS-1:0][PAIR_W-1:0]  pair_lo_ff, pair_lo_in;
   logic [LEVELS-1:0][PAIR_W-1:0]  pair_hi_ff, pair_hi_in;
   logic [LEVELS-1:0][SIZE_W-1:0]  size_ff, size_in;
   logic [LEVELS-1:0][EDGE_W-1:0]  size_up_ff, size_up_in;
   logic [LEVELS:0][NODE_W-1:0]    node_off_ff, node_off_in;
   logic [LEVELS-1:0][EDGE_W-1:0]  edge_off_ff, edge_off_in;

   // Counts above the maximum saturate on write.
   always_comb begin
      wr_value = (csr_wdata > MAX_LINKS_VAL) ? MAX_LINKS_VAL : csr_wdata;
      up_in    = up_ff;
      down_in  = down_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_UP_LINKS_0:   up_in[0]   = wr_value;
            CSR_UP_LINKS_1:   up_in[1]   = wr_value;
            CSR_UP_LINKS_2:   up_in[2]   = wr_value;
            CSR_UP_LINKS_3:   up_in[3]   = wr_value;
            CSR_DOWN_LINKS_0: down_in[0] = wr_value;
            CSR_DOWN_LINKS_1: down_in[1] = wr_value;
            CSR_DOWN_LINKS_2: down_in[2] = wr_value;
            CSR_DOWN_LINKS_3: down_in[3] = wr_value;
            default: begin
               up_in   = up_ff;
               down_in = down_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff   <= {link_type'(1), link_type'(2), link_type'(2), link_type'(1)};
         down_ff <= {link_type'(1), link_type'(4), link_type'(2), link_type'(2)};
      end else begin
         up_ff   <= up_in;
         down_ff <= down_in;
      end
   end

   // Layer size is the product of the four radices, built as two pairs first.
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         pair_lo_in[l] = PAIR_W'(level_radix(up_ff, down_ff, 0, layer_type'(l)))
                       * PAIR_W'(level_radix(up_ff, down_ff, 1, layer_type'(l)));
         pair_hi_in[l] = PAIR_W'(level_radix(up_ff, down_ff, 2, layer_type'(l)))
                       * PAIR_W'(level_radix(up_ff, down_ff, 3, layer_type'(l)));
         size_in[l]    = SIZE_W'(pair_lo_ff[l]) * SIZE_W'(pair_hi_ff[l]);
         size_up_in[l] = EDGE_W'(size_ff[l]) * EDGE_W'(up_ff[l]);
      end
      node_off_in[0] = '0;
      for (int l = 0; l < LEVELS; l++) begin
         node_off_in[l+1] = node_off_in[l] + NODE_W'(size_ff[l]);
      end
      edge_off_in[0] = '0;
      for (int l = 0; l < LEVELS-1; l++) begin
         edge_off_in[l+1] = edge_off_in[l] + size_up_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      pair_lo_ff  <= pair_lo_in;
      pair_hi_ff  <= pair_hi_in;
      size_ff     <= size_in;
      size_up_ff  <= size_up_in;
      node_off_ff <= node_off_in;
      edge_off_ff <= edge_off_in;
   end

   assign links.up_links    = up_ff;
   assign links.down_links  = down_ff;
   assign links.node_offset = node_off_ff;
   assign links.edge_offset = edge_off_ff;

endmodule

/* sv/ftpe_index_pipe.sv */
// Six-stage pipeline that forms the parent digits, node number and edge number.
// Depends on ftpe_pkg and on the offsets from ftpe_link_table.
`timescale 1ns / 1ps

module ftpe_index_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ftpe_pkg::query_type   query,
   input  ftpe_pkg::links_type   links,
   output logic                  out_valid,
   output ftpe_pkg::result_type  result
);
   import ftpe_pkg::*;

   typedef struct packed {
      logic                     root;
      layer_type                layer;
      digit_type [LEVELS-1:0]   cdig;
      digit_type [LEVELS-1:0]   pdig;
      link_type [LEVELS-2:0]    rc;
      link_type [LEVELS-2:0]    rp;
      link_type                 upc;
      digit_type                pd;
   } ctx_type;

   logic [CTX_STAGES-1:0]   valid_ff, valid_in;
   ctx_type [CTX_STAGES-1:0] ctx_ff, ctx_in;
   logic [H1_W-1:0]         h1_node_ff, h1_node_in, h1_edge_ff, h1_edge_in;
   logic [H2_W-1:0]         h2_node_ff, h2_node_in, h2_edge_ff, h2_edge_in;
   logic [H3_W-1:0]         h3_node_ff, h3_node_in, h3_edge_ff, h3_edge_in;
   logic [NODE_W-1:0]       node_id_ff, node_id_in;
   logic [EDGE_W-1:0]       edge_mul_ff, edge_mul_in;
   logic                    out_valid_ff;
   result_type              result_ff, result_in;
   digit_type [LEVELS-1:0]  cdig, rdig;
   logic                    same;
   logic                    top;
   layer_type               child_layer;
   layer_type               s5_parent_layer;
   logic [LVL_IDX_W-1:0]    lvl;

   // Stage one: compare with the root, swap in the root digit, pick the radices.
   always_comb begin
      same = (query.child_layer == query.root_layer);
      for (int i = 0; i < LEVELS; i++) begin
         if (i < TREE_HEIGHT) begin
            cdig[i] = query.child_digit[i];
            rdig[i] = query.root_digit[i];
         end else begin
            cdig[i] = '0;
            rdig[i] = '0;
         end
         if (cdig[i] != rdig[i]) begin
            same = 1'b0;
         end
      end
      top         = (query.child_layer >= TOP_LAYER);
      // A node on the top layer has no parent; its layer is parked at zero so
      // that later offset lookups stay in range.
      child_layer = top ? '0 : query.child_layer;
      lvl         = child_layer[LVL_IDX_W-1:0];

      ctx_in[0].root      = same || top;
      ctx_in[0].layer     = child_layer;
      ctx_in[0].cdig      = cdig;
      ctx_in[0].pdig      = cdig;
      ctx_in[0].pdig[lvl] = rdig[lvl];
      for (int i = 0; i < LEVELS-1; i++) begin
         ctx_in[0].rc[i] = level_radix(links.up_links, links.down_links, i, child_layer);
         ctx_in[0].rp[i] = level_radix(links.up_links, links.down_links, i,
                                       layer_type'(child_layer + LAYER_ONE));
      end
      ctx_in[0].upc = links.up_links[lvl];
      ctx_in[0].pd  = rdig[lvl];
      for (int s = 1; s < CTX_STAGES; s++) begin
         ctx_in[s] = ctx_ff[s-1];
      end

      valid_in[0] = in_valid;
      for (int s = 1; s < CTX_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   // Stages two to four: one Horner step each, from the top digit down.
   always_comb begin
      h1_node_in = H1_W'(ctx_ff[0].pdig[LEVELS-1]) * H1_W'(ctx_ff[0].rp[LEVELS-2])
                 + H1_W'(ctx_ff[0].pdig[LEVELS-2]);
      h1_edge_in = H1_W'(ctx_ff[0].cdig[LEVELS-1]) * H1_W'(ctx_ff[0].rc[LEVELS-2])
                 + H1_W'(ctx_ff[0].cdig[LEVELS-2]);
      h2_node_in = H2_W'(h1_node_ff) * H2_W'(ctx_ff[1].rp[1]) + H2_W'(ctx_ff[1].pdig[1]);
      h2_edge_in = H2_W'(h1_edge_ff) * H2_W'(ctx_ff[1].rc[1]) + H2_W'(ctx_ff[1].cdig[1]);
      h3_node_in = H3_W'(h2_node_ff) * H3_W'(ctx_ff[2].rp[0]) + H3_W'(ctx_ff[2].pdig[0]);
      h3_edge_in = H3_W'(h2_edge_ff) * H3_W'(ctx_ff[2].rc[0]) + H3_W'(ctx_ff[2].cdig[0]);
   end

   // Stage five: node offset added; edge digit sum scaled by the uplink count.
   always_comb begin
      s5_parent_layer = layer_type'(ctx_ff[3].layer + LAYER_ONE);
      node_id_in      = NODE_W'(h3_node_ff) + links.node_offset[s5_parent_layer];
      edge_mul_in     = EDGE_W'(h3_edge_ff) * EDGE_W'(ctx_ff[3].upc);
   end

   // Stage six: edge offset and parent port added; the root gives all zeros.
   always_comb begin
      if (ctx_ff[4].root) begin
         result_in              = '0;
         result_in.reached_root = 1'b1;
      end else begin
         result_in.reached_root   = 1'b0;
         result_in.parent_layer   = layer_type'(ctx_ff[4].layer + LAYER_ONE);
         result_in.parent_node_id = node_id_ff;
         result_in.edge_id        = edge_mul_ff
                                  + links.edge_offset[ctx_ff[4].layer[LVL_IDX_W-1:0]]
                                  + EDGE_W'(ctx_ff[4].pd);
         result_in.parent_digit   = ctx_ff[4].pdig;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[CTX_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff      <= ctx_in;
      h1_node_ff  <= h1_node_in;
      h1_edge_ff  <= h1_edge_in;
      h2_node_ff  <= h2_node_in;
      h2_edge_ff  <= h2_edge_in;
      h3_node_ff  <= h3_node_in;
      h3_edge_ff  <= h3_edge_in;
      node_id_ff  <= node_id_in;
      edge_mul_ff <= edge_mul_in;
      result_ff   <= result_in;
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

endmodule

/* sv/fat_tree_parent_edge_index.sv */
// Fat-tree parent and edge indexer, top level; uses ftpe_pkg, ftpe_link_table, ftpe_index_pipe.
// Throughput: one query per cycle while busy is low, set by the six-stage multiply-add pipeline.
// busy is high after reset and after each csr write while the registered
// layer-size products rebuild; the result side never stalls.
// Reset is synchronous and active high; link counts return to their defaults.
`timescale 1ns / 1ps

module fat_tree_parent_edge_index (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  ftpe_pkg::layer_type      req_child_layer,
   input  ftpe_pkg::digit_type      req_child_digit_0,
   input  ftpe_pkg::digit_type      req_child_digit_1,
   input  ftpe_pkg::digit_type      req_child_digit_2,
   input  ftpe_pkg::digit_type      req_child_digit_3,
   input  ftpe_pkg::layer_type      req_root_layer,
   input  ftpe_pkg::digit_type      req_root_digit_0,
   input  ftpe_pkg::digit_type      req_root_digit_1,
   input  ftpe_pkg::digit_type      req_root_digit_2,
   input  ftpe_pkg::digit_type      req_root_digit_3,
   output logic                     rsp_valid,
   output logic                     rsp_reached_root,
   output ftpe_pkg::layer_type      rsp_parent_layer,
   output logic [26:0]              rsp_parent_node_id,
   output logic [31:0]              rsp_edge_id,
   output ftpe_pkg::digit_type      rsp_parent_digit_0,
   output ftpe_pkg::digit_type      rsp_parent_digit_1,
   output ftpe_pkg::digit_type      rsp_parent_digit_2,
   output ftpe_pkg::digit_type      rsp_parent_digit_3,
   input  logic                     csr_we,
   input  ftpe_pkg::csr_index_type  csr_index,
   input  ftpe_pkg::link_type       csr_wdata
);
   import ftpe_pkg::*;

   settle_type settle_ff, settle_in;
   query_type  query;
   links_type  links;
   result_type result;
   logic       accept;

   always_comb begin
      if (csr_we) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_type'(settle_ff - 1'b1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign busy   = (settle_ff != '0);
   assign accept = start && !busy;

   assign query.child_layer    = req_child_layer;
   assign query.child_digit[0] = req_child_digit_0;
   assign query.child_digit[1] = req_child_digit_1;
   assign query.child_digit[2] = req_child_digit_2;
   assign query.child_digit[3] = req_child_digit_3;
   assign query.root_layer     = req_root_layer;
   assign query.root_digit[0]  = req_root_digit_0;
   assign query.root_digit[1]  = req_root_digit_1;
   assign query.root_digit[2]  = req_root_digit_2;
   assign query.root_digit[3]  = req_root_digit_3;

   ftpe_link_table u_link_table (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .links     (links)
   );

   ftpe_index_pipe u_index_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .query     (query),
      .links     (links),
      .out_valid (rsp_valid),
      .result    (result)
   );

   assign rsp_reached_root   = result.reached_root;
   assign rsp_parent_layer   = result.parent_layer;
   assign rsp_parent_node_id = result.parent_node_id;
   assign rsp_edge_id        = result.edge_id;
   assign rsp_parent_digit_0 = result.parent_digit[0];
   assign rsp_parent_digit_1 = result.parent_digit[1];
   assign rsp_parent_digit_2 = result.parent_digit[2];
   assign rsp_parent_digit_3 = result.parent_digit[3];

`ifndef SYNTHESIS
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("accepted query did not produce a result after six cycles");

   a_write_blocks_start: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy)
      else $error("query port open right after a link-count write");

   a_root_all_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reached_root) |->
         (rsp_parent_layer == '0 && rsp_parent_node_id == '0 && rsp_edge_id == '0 &&
          rsp_parent_digit_0 == '0 && rsp_parent_digit_1 == '0 &&
          rsp_parent_digit_2 == '0 && rsp_parent_digit_3 == '0))
      else $error("root result carries nonzero fields");

   a_parent_layer_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reached_root) |->
         (rsp_parent_layer != '0 && rsp_parent_layer <= TOP_LAYER))
      else $error("parent layer outside the tree");
`endif

endmodule
